// File: rtl/core/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Types, codes and helpers shared by the branch statistics table modules.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int CNT_W  = 32;
  localparam int IN_W   = 88;
  localparam int OUT_W  = 176;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_OUTCOME   = 2'd0,
    REQ_OCCUPANCY = 2'd1,
    REQ_READ      = 2'd2,
    REQ_FLUSH     = 2'd3
  } bst_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DECIDE,
    ST_CLEAR,
    ST_READ,
    ST_UPDATE,
    ST_RESULT
  } bst_state_e;

  // input item, last-declared field in the lowest bits
  typedef struct packed {
    logic [3:0]  pad;
    logic [5:0]  read_bin;
    logic [5:0]  read_index;
    logic [5:0]  active_lanes;
    logic        taken;
    logic [31:0] target_pc;
    logic [31:0] source_pc;
    logic        branch_kind;
  } bst_in_t;

  // result item, last-declared field in the lowest bits
  typedef struct packed {
    logic [5:0]       pad;
    logic [CNT_W-1:0] bin_count;
    logic [CNT_W-1:0] taken_total;
    logic [CNT_W-1:0] instance_count;
    logic [31:0]      target_out;
    logic [31:0]      source_out;
    logic             kind_out;
    logic             entry_valid;
    logic             table_full;
    logic             hit;
    logic [5:0]       entry_index;
  } bst_res_t;

  // one word of the entry memory
  typedef struct packed {
    logic             kind;
    logic [31:0]      src;
    logic [31:0]      tgt;
    logic [CNT_W-1:0] inst;
    logic [CNT_W-1:0] tk;
  } bst_entry_t;

  typedef struct packed {
    logic load;
    logic match;
    logic alloc;
    logic clr;
    logic rd;
    logic upd;
    logic flush;
    logic full;
    logic emit;
  } bst_cmd_t;

  typedef struct packed {
    bst_req_e req;
    logic     hit;
    logic     full;
    logic     clr_last;
    logic     out_free;
  } bst_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// File: rtl/core/bst_ram.sv
// ----------------------------------------------------------------------------
// bst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bst_ctrl.sv
// ----------------------------------------------------------------------------
// bst_ctrl
// Request sequencer: lookup, allocation with bin clear, counter update.
// ----------------------------------------------------------------------------
module bst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bst_pkg::bst_status_t status_i,
  output bst_pkg::bst_cmd_t    cmd_o
);
  import bst_pkg::*;

  bst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        case (status_i.req)
          REQ_FLUSH: begin
            cmd_o.flush = 1'b1;
            state_d     = ST_RESULT;
          end
          REQ_READ: begin
            state_d = ST_READ;
          end
          default: begin
            if (status_i.hit) begin
              state_d = ST_READ;
            end else if (status_i.full) begin
              cmd_o.full = 1'b1;
              state_d    = ST_RESULT;
            end else begin
              cmd_o.alloc = 1'b1;
              state_d     = ST_CLEAR;
            end
          end
        endcase
      end
      ST_CLEAR: begin
        // zero the new entry's histogram, one bin a cycle
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/bst_datapath.sv
// ----------------------------------------------------------------------------
// bst_datapath
// Key registers with parallel match, entry and histogram memories, result.
// ----------------------------------------------------------------------------
module bst_datapath #(
  parameter int CAPACITY  = 64,
  parameter int LANES     = 32,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bst_pkg::bst_cmd_t    cmd_i,
  output bst_pkg::bst_status_t status_o,
  input  bst_pkg::bst_req_e    req_i,
  input  bst_pkg::bst_in_t     data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bst_pkg::bst_res_t    out_data_o
);
  import bst_pkg::*;

  localparam int NBINS = LANES + 1;
  localparam int IW    = $clog2(CAPACITY);
  localparam int UW    = $clog2(CAPACITY + 1);
  localparam int BW    = $clog2(NBINS);
  localparam int HD    = CAPACITY * NBINS;
  localparam int HA    = $clog2(HD);
  localparam int KW    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int EW    = $bits(bst_entry_t);

  bst_req_e       req_q;
  bst_in_t        in_q;
  logic [UW-1:0]  used_q;
  logic [IW-1:0]  idx_q;
  logic           hit_q;
  logic [BW-1:0]  clr_q;
  logic [KW-1:0]  key_src_q [CAPACITY];
  logic [KW-1:0]  key_tgt_q [CAPACITY];
  bst_res_t       res_q;
  logic           out_valid_q;
  bst_res_t       out_data_q;

  logic           match_any;
  logic [IW-1:0]  match_idx;
  logic [KW-1:0]  src_key, tgt_key;
  logic           rd_ok, rb_ok;
  logic [BW-1:0]  bin_sel, bin_addr;
  logic [HA-1:0]  h_addr;
  logic           ent_we, hist_we;
  bst_entry_t     ent_wdata, ent_rd, ent_new;
  logic [EW-1:0]  ent_rdata;
  logic [CNT_W-1:0] hist_wdata, hist_rdata;
  bst_res_t       res_upd;
  bst_res_t       res_full;

  assign src_key = in_q.source_pc[KW-1:0];
  assign tgt_key = in_q.target_pc[KW-1:0];

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (UW'(j) < used_q && key_src_q[j] == src_key && key_tgt_q[j] == tgt_key) begin
        match_any = 1'b1;
        match_idx = IW'(j);
      end
    end
  end

  assign rd_ok = 32'(in_q.read_index) < 32'(used_q);
  assign rb_ok = {1'b0, in_q.read_bin} <= 7'(LANES);

  // pick the histogram bin: clamp lane count, drop out-of-range read bins
  always_comb begin
    case (req_q)
      REQ_OCCUPANCY: begin
        if ({1'b0, in_q.active_lanes} > 7'(LANES)) begin
          bin_sel = BW'(LANES);
        end else begin
          bin_sel = BW'(in_q.active_lanes);
        end
      end
      REQ_READ: bin_sel = rb_ok ? BW'(in_q.read_bin) : '0;
      default:  bin_sel = '0;
    endcase
  end

  assign bin_addr = cmd_i.clr ? clr_q : bin_sel;
  assign h_addr   = HA'(idx_q) * HA'(NBINS) + HA'(bin_addr);

  assign ent_rd  = bst_entry_t'(ent_rdata);

  always_comb begin
    ent_new      = ent_rd;
    ent_new.inst = sat_inc(ent_rd.inst);
    if (in_q.taken) begin
      ent_new.tk = sat_inc(ent_rd.tk);
    end
  end

  always_comb begin
    if (cmd_i.alloc) begin
      ent_wdata      = '0;
      ent_wdata.kind = in_q.branch_kind;
      ent_wdata.src  = 32'(src_key);
      ent_wdata.tgt  = 32'(tgt_key);
    end else begin
      ent_wdata = ent_new;
    end
  end

  assign ent_we     = cmd_i.alloc || (cmd_i.upd && req_q == REQ_OUTCOME);
  assign hist_we    = cmd_i.clr || (cmd_i.upd && req_q == REQ_OCCUPANCY);
  assign hist_wdata = cmd_i.clr ? '0 : sat_inc(hist_rdata);

  always_comb begin
    res_full            = '0;
    res_full.table_full = 1'b1;
  end

  always_comb begin
    res_upd = '0;
    if (req_q == REQ_READ) begin
      res_upd.entry_index = in_q.read_index;
      if (rd_ok) begin
        res_upd.entry_valid    = 1'b1;
        res_upd.kind_out       = ent_rd.kind;
        res_upd.source_out     = ent_rd.src;
        res_upd.target_out     = ent_rd.tgt;
        res_upd.instance_count = ent_rd.inst;
        res_upd.taken_total    = ent_rd.tk;
        res_upd.bin_count      = rb_ok ? hist_rdata : '0;
      end
    end else begin
      res_upd.entry_index = 6'(idx_q);
      res_upd.hit         = hit_q;
      res_upd.entry_valid = 1'b1;
      res_upd.kind_out    = ent_rd.kind;
      res_upd.source_out  = ent_rd.src;
      res_upd.target_out  = ent_rd.tgt;
      if (req_q == REQ_OUTCOME) begin
        res_upd.instance_count = ent_new.inst;
        res_upd.taken_total    = ent_new.tk;
      end else begin
        res_upd.instance_count = ent_rd.inst;
        res_upd.taken_total    = ent_rd.tk;
        res_upd.bin_count      = sat_inc(hist_rdata);
      end
    end
  end

  bst_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (idx_q),
    .wdata_i (ent_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (ent_rdata)
  );

  bst_ram #(.WIDTH(CNT_W), .DEPTH(HD)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (h_addr),
    .wdata_i (hist_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (h_addr),
    .rdata_o (hist_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      in_q  <= data_i;
    end
    if (cmd_i.match) begin
      hit_q <= match_any;
      if (req_q == REQ_READ) begin
        idx_q <= IW'(in_q.read_index);
      end else if (match_any) begin
        idx_q <= match_idx;
      end else begin
        idx_q <= IW'(used_q);
      end
    end
    if (cmd_i.alloc) begin
      key_src_q[idx_q] <= src_key;
      key_tgt_q[idx_q] <= tgt_key;
    end
    if (cmd_i.upd) begin
      res_q <= res_upd;
    end else if (cmd_i.flush) begin
      res_q <= '0;
    end else if (cmd_i.full) begin
      res_q <= res_full;
    end
    if (cmd_i.emit) begin
      out_data_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.flush) begin
        used_q <= '0;
      end else if (cmd_i.alloc) begin
        used_q <= used_q + UW'(1);
      end
      if (cmd_i.alloc) begin
        clr_q <= '0;
      end else if (cmd_i.clr) begin
        clr_q <= clr_q + BW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.req      = req_q;
  assign status_o.hit      = hit_q;
  assign status_o.full     = (used_q == UW'(CAPACITY));
  assign status_o.clr_last = (clr_q == BW'(LANES));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/core/branch_statistics_table_unit.sv
// ----------------------------------------------------------------------------
// branch_statistics_table_unit
// Table of branch counters and active-lane histograms keyed by source/target.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (tuser = request type), one result
//   item per request leaves on the m_axis channel.
//   Request types: branch outcome, occupancy sample, read entry, flush.
//   A request runs through lookup, decide, memory read and update steps
//   before its result is formed: an item that hits or a read takes all of
//   them; a flush or a new key on a full table skips the memory steps.
//   Allocating a new entry adds a clearing step that zeroes its LANES+1
//   histogram bins, one bin per cycle through the histogram memory's single
//   write port. The next request is accepted only once the sequencer is back
//   in idle after loading the result into the output register.
//   The output register holds a result while m_axis_tready is low; the
//   sequencer then waits in its result step and takes no new request.
//   Reset empties the table; no clearing pass is needed since every entry's
//   counters are zeroed when it is allocated.
// ----------------------------------------------------------------------------
module branch_statistics_table_unit #(
  parameter int CAPACITY  = 64,
  parameter int LANES     = 32,
  parameter int ADDR_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // branch_kind, source_pc, target_pc, taken, active_lanes, read_index,
  // read_bin, zero pad
  input  logic [bst_pkg::IN_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // entry_index, hit, table_full, entry_valid, kind_out, source_out,
  // target_out, instance_count, taken_total, bin_count, zero pad
  output logic [bst_pkg::OUT_W-1:0] m_axis_tdata
);
  import bst_pkg::*;

  bst_cmd_t    cmd;
  bst_status_t status;
  bst_res_t    out_data;

  bst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bst_datapath #(
    .CAPACITY  (CAPACITY),
    .LANES     (LANES),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (bst_req_e'(s_axis_tuser)),
    .data_i      (bst_in_t'(s_axis_tdata)),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = out_data;

endmodule

// File: rtl/core/bst_checker.sv
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks on the result channel of the branch statistics table.
// ----------------------------------------------------------------------------
module bst_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [bst_pkg::OUT_W-1:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a full-table result carries nothing else
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7] |->
      m_axis_tdata[6:0] == 7'd0 && m_axis_tdata[175:8] == '0)
    else $error("full-table result carries data");

  // a hit always names a live entry
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[8] && !m_axis_tdata[7])
    else $error("hit on an empty entry");

  // an empty entry reports no key or counters
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[175:9] == '0)
    else $error("empty entry reports data");

endmodule

bind branch_statistics_table_unit bst_checker u_bst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
